// ----- sv/rfs_pkg.sv -----
`default_nettype none

package rfs_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam int          HDR_LEN  = 6;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECIDE,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_SEND
    } state_t;

    typedef enum logic [2:0] {
        STATUS_OK       = 3'd0,
        STATUS_RD_RANGE = 3'd1,
        STATUS_RD_CRC   = 3'd2,
        STATUS_WR_RANGE = 3'd3,
        STATUS_WR_CRC   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CFG_SLAVE_ADDRESS = 2'd0,
        CFG_READ_CODE     = 2'd1,
        CFG_WRITE_CODE    = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic       init;
        logic       update;
        logic [7:0] data;
    } crc_ctrl_t;

    typedef struct packed {
        logic [7:0] addr;
        logic [7:0] group;
        logic [7:0] start;
        logic [7:0] count;
        logic [7:0] request;
        logic [7:0] crc_hi;
        logic [7:0] crc_lo;
    } frame_hdr_t;

    // one byte of reflected CRC-16
    function automatic logic [15:0] crc_add(input logic [15:0] crc_in, input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- sv/register_frame_slave_unit.sv -----
// Register frame slave.
// Item channel (item_valid/item_stall): with func low, one received link byte
// (frame_start marks byte 0); with func high, a local write of byte_value into
// group reg_group at reg_index. Config port: cfg_we/cfg_index/cfg_data.
// A frame is DATA_BYTES+8 bytes. Its last byte, when addressed to this slave
// with a read or write request, triggers a response of DATA_BYTES+8 bytes on
// the result channel (result_valid/result_stall), one per transaction.
// After the last byte: a decision state, then on a good write a read state
// and a write state per stored byte, then one response byte per cycle while
// the result is not stalled; item_stall is high from the last byte until the
// final response byte sits in the output register. One CRC-16 byte unit
// serves both the receive check and the response CRC, one byte per cycle when
// not stalled. Reset clears the register file by a pass, one entry per cycle,
// with item_stall high; config writes are taken.
// A stalled result holds in the output register and the response sequencer
// waits for it.
`default_nettype none

module register_frame_slave_unit
    import rfs_pkg::*;
#(
    parameter int DATA_BYTES = 16,
    parameter int NUM_GROUPS = 8
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data,
    input  wire logic       item_valid,
    output logic            item_stall,
    input  wire logic       func,
    input  wire logic       frame_start,
    input  wire logic [7:0] byte_value,
    input  wire logic [3:0] reg_group,
    input  wire logic [3:0] reg_index,
    output logic            result_valid,
    input  wire logic       result_stall,
    output logic      [7:0] tx_byte,
    output logic            tx_last,
    output logic            is_error,
    output logic      [2:0] status_code
);

    localparam int FRAME_LEN = DATA_BYTES + 8;
    localparam int CRC_SPAN  = DATA_BYTES + 6;
    localparam int RF_DEPTH  = NUM_GROUPS * DATA_BYTES;
    localparam int RF_AW     = (RF_DEPTH > 1) ? $clog2(RF_DEPTH) : 1;
    localparam int FD_AW     = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1;
    localparam int TX_W      = $clog2(FRAME_LEN);
    localparam int LEFT_W    = $clog2(DATA_BYTES + 1);

    state_t            state_reg;
    state_t            state_next;
    logic [7:0]        slave_address_reg;
    logic [7:0]        read_code_reg;
    logic [7:0]        write_code_reg;

    logic              item_accept;
    logic              link_en;
    logic              local_en;
    logic              local_ok;
    logic [RF_AW-1:0]  local_addr;

    frame_hdr_t        hdr;
    logic              rx_last;
    logic [7:0]        fd_rdata;
    crc_ctrl_t         rx_crc_ctrl;
    crc_ctrl_t         tx_crc_ctrl;
    crc_ctrl_t         crc_ctrl;
    logic [15:0]       crc;

    logic              addr_match;
    logic              is_read;
    logic              is_write;
    logic              group_ok;
    logic              rd_range_bad;
    logic              wr_range_bad;
    logic              crc_good;
    logic              dec_respond;
    logic              dec_send_regs;
    logic              dec_copy;
    status_t           dec_status;
    logic [RF_AW-1:0]  dec_base;
    logic [RF_AW-1:0]  dec_rf_ptr;

    status_t           status_reg;
    logic              send_regs_reg;
    logic [RF_AW-1:0]  base_reg;
    logic [RF_AW-1:0]  rf_ptr_reg;
    logic [FD_AW-1:0]  fd_ptr_reg;
    logic [LEFT_W-1:0] copy_left_reg;
    logic [LEFT_W-1:0] copy_left_next;
    logic [RF_AW-1:0]  clr_idx_reg;
    logic [RF_AW-1:0]  clr_idx_next;
    logic [TX_W-1:0]   tx_idx_reg;
    logic [TX_W-1:0]   tx_idx_next;

    logic              rf_we;
    logic [RF_AW-1:0]  rf_waddr;
    logic [7:0]        rf_wdata;
    logic [RF_AW-1:0]  rf_raddr;
    logic [15:0]       rd_sum;
    logic [7:0]        rf_rdata;

    logic              tx_load;
    logic [7:0]        tx_data;
    logic              result_valid_reg;
    logic [7:0]        tx_byte_reg;
    logic              tx_last_reg;
    logic              is_error_reg;
    status_t           status_code_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_address_reg <= 8'd1;
            read_code_reg     <= 8'd1;
            write_code_reg    <= 8'd2;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SLAVE_ADDRESS: slave_address_reg <= cfg_data;
                CFG_READ_CODE:     read_code_reg     <= cfg_data;
                CFG_WRITE_CODE:    write_code_reg    <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign item_accept = item_valid && !item_stall;
    assign link_en     = item_accept && !func;
    assign local_en    = item_accept && func;
    assign local_ok    = (reg_group != 4'd0) && (32'(reg_group) <= NUM_GROUPS)
                         && (32'(reg_index) < DATA_BYTES);
    assign local_addr  = RF_AW'(32'(reg_group - 4'd1) * DATA_BYTES + 32'(reg_index));

    rfs_frame_rx #(
        .DATA_BYTES (DATA_BYTES),
        .FD_AW      (FD_AW)
    ) u_frame_rx (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_en     (link_en),
        .frame_start (frame_start),
        .byte_value  (byte_value),
        .fd_raddr    (fd_ptr_reg),
        .hdr         (hdr),
        .last_byte   (rx_last),
        .fd_rdata    (fd_rdata),
        .crc_ctrl    (rx_crc_ctrl)
    );

    assign crc_ctrl = (state_reg == ST_IDLE) ? rx_crc_ctrl : tx_crc_ctrl;

    rfs_crc_unit u_crc_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (crc_ctrl),
        .crc   (crc)
    );

    rfs_regfile #(
        .DEPTH (RF_DEPTH),
        .AW    (RF_AW)
    ) u_regfile (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .raddr (rf_raddr),
        .rdata (rf_rdata)
    );

    // frame decision, range before CRC
    always_comb
    begin
        addr_match   = hdr.addr == slave_address_reg;
        is_read      = hdr.request == read_code_reg;
        is_write     = !is_read && (hdr.request == write_code_reg);
        group_ok     = (hdr.group != 8'd0) && (32'(hdr.group) <= NUM_GROUPS);
        rd_range_bad = (32'(hdr.count) > DATA_BYTES) || !group_ok;
        wr_range_bad = rd_range_bad || (32'(hdr.start) > DATA_BYTES)
                       || ((32'(hdr.start) + 32'(hdr.count)) > DATA_BYTES);
        crc_good     = (hdr.crc_hi == crc[15:8]) && (hdr.crc_lo == crc[7:0]);
        dec_respond  = addr_match && (is_read || is_write);
        priority if (is_read && rd_range_bad)
        begin
            dec_status = STATUS_RD_RANGE;
        end
        else if (is_read && !crc_good)
        begin
            dec_status = STATUS_RD_CRC;
        end
        else if (is_write && wr_range_bad)
        begin
            dec_status = STATUS_WR_RANGE;
        end
        else if (is_write && !crc_good)
        begin
            dec_status = STATUS_WR_CRC;
        end
        else
        begin
            dec_status = STATUS_OK;
        end
        dec_send_regs = is_read && (dec_status == STATUS_OK);
        dec_copy      = is_write && (dec_status == STATUS_OK) && (hdr.count != 8'd0);
        dec_base      = RF_AW'(32'(hdr.group - 8'd1) * DATA_BYTES);
        dec_rf_ptr    = RF_AW'(32'(hdr.group - 8'd1) * DATA_BYTES + 32'(hdr.start));
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_idx_reg == RF_AW'(RF_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (rx_last)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (!dec_respond)
                begin
                    state_next = ST_IDLE;
                end
                else if (dec_copy)
                begin
                    state_next = ST_COPY_RD;
                end
                else
                begin
                    state_next = ST_SEND;
                end
            end
            ST_COPY_RD:
            begin
                state_next = ST_COPY_WR;
            end
            ST_COPY_WR:
            begin
                if (copy_left_reg == LEFT_W'(1))
                begin
                    state_next = ST_SEND;
                end
                else
                begin
                    state_next = ST_COPY_RD;
                end
            end
            ST_SEND:
            begin
                if (tx_load && (tx_idx_reg == TX_W'(FRAME_LEN - 1)))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        unique case (tx_idx_reg)
            TX_W'(0):             tx_data = slave_address_reg;
            TX_W'(1):             tx_data = hdr.group;
            TX_W'(2):             tx_data = hdr.start;
            TX_W'(3):             tx_data = hdr.count;
            TX_W'(4):             tx_data = hdr.request;
            TX_W'(5):             tx_data = {5'b00000, status_reg};
            TX_W'(FRAME_LEN - 2): tx_data = crc[15:8];
            TX_W'(FRAME_LEN - 1): tx_data = crc[7:0];
            default:              tx_data = send_regs_reg ? rf_rdata : 8'h00;
        endcase
    end

    always_comb
    begin
        item_stall     = state_reg != ST_IDLE;
        tx_load        = (state_reg == ST_SEND) && (!result_valid_reg || !result_stall);
        rf_we          = 1'b0;
        rf_waddr       = clr_idx_reg;
        rf_wdata       = 8'h00;
        tx_crc_ctrl    = '0;
        tx_idx_next    = tx_idx_reg;
        clr_idx_next   = clr_idx_reg;
        copy_left_next = copy_left_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                rf_we        = 1'b1;
                clr_idx_next = clr_idx_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (local_en && local_ok)
                begin
                    rf_we    = 1'b1;
                    rf_waddr = local_addr;
                    rf_wdata = byte_value;
                end
            end
            ST_DECIDE:
            begin
                tx_crc_ctrl.init = 1'b1;
                tx_idx_next      = '0;
                copy_left_next   = LEFT_W'(hdr.count);
            end
            ST_COPY_RD:
            begin
            end
            ST_COPY_WR:
            begin
                rf_we          = 1'b1;
                rf_waddr       = rf_ptr_reg;
                rf_wdata       = fd_rdata;
                copy_left_next = copy_left_reg - 1'b1;
            end
            ST_SEND:
            begin
                if (tx_load)
                begin
                    tx_crc_ctrl.update = 32'(tx_idx_reg) < CRC_SPAN;
                    tx_crc_ctrl.data   = tx_data;
                    tx_idx_next        = tx_idx_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // read address follows the next byte index so data is ready on load
    assign rd_sum   = 16'(base_reg) + 16'(tx_idx_next) - 16'(HDR_LEN);
    assign rf_raddr = rd_sum[RF_AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_idx_reg      <= '0;
            tx_idx_reg       <= '0;
            copy_left_reg    <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            tx_idx_reg    <= tx_idx_next;
            copy_left_reg <= copy_left_next;
            if (tx_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DECIDE)
        begin
            status_reg    <= dec_status;
            send_regs_reg <= dec_send_regs;
            base_reg      <= dec_base;
            rf_ptr_reg    <= dec_rf_ptr;
            fd_ptr_reg    <= FD_AW'(hdr.start);
        end
        else if (state_reg == ST_COPY_WR)
        begin
            rf_ptr_reg <= rf_ptr_reg + 1'b1;
            fd_ptr_reg <= fd_ptr_reg + 1'b1;
        end
        if (tx_load)
        begin
            tx_byte_reg     <= tx_data;
            tx_last_reg     <= tx_idx_reg == TX_W'(FRAME_LEN - 1);
            is_error_reg    <= status_reg != STATUS_OK;
            status_code_reg <= status_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign tx_byte      = tx_byte_reg;
    assign tx_last      = tx_last_reg;
    assign is_error     = is_error_reg;
    assign status_code  = status_code_reg;

    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_CLEAR) |=> (state_reg != ST_CLEAR))
        else $error("clearing pass restarted");

    a_copy_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COPY_WR) |-> (copy_left_reg != '0))
        else $error("copy ran past its count");

    a_rf_addr: assert property (@(posedge clk) disable iff (!rst_n)
        rf_we |-> (32'(rf_waddr) < RF_DEPTH))
        else $error("register file write out of range");

    a_status_err: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (is_error_reg == (status_code_reg != STATUS_OK)))
        else $error("error flag disagrees with status");

endmodule

`default_nettype wire

// ----- sv/rfs_crc_unit.sv -----
`default_nettype none

module rfs_crc_unit
    import rfs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire crc_ctrl_t   ctrl,
    output logic      [15:0] crc
);

    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [15:0] crc_base;

    always_comb
    begin
        crc_base = ctrl.init ? CRC_INIT : crc_reg;
        crc_next = crc_reg;
        if (ctrl.update)
        begin
            crc_next = crc_add(crc_base, ctrl.data);
        end
        else if (ctrl.init)
        begin
            crc_next = CRC_INIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= CRC_INIT;
        end
        else
        begin
            crc_reg <= crc_next;
        end
    end

    assign crc = crc_reg;

endmodule

`default_nettype wire

// ----- sv/rfs_frame_rx.sv -----
`default_nettype none

module rfs_frame_rx
    import rfs_pkg::*;
#(
    parameter int DATA_BYTES = 16,
    parameter int FD_AW      = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             byte_en,
    input  wire logic             frame_start,
    input  wire logic [7:0]       byte_value,
    input  wire logic [FD_AW-1:0] fd_raddr,
    output frame_hdr_t            hdr,
    output logic                  last_byte,
    output logic      [7:0]       fd_rdata,
    output crc_ctrl_t             crc_ctrl
);

    localparam int FRAME_LEN = DATA_BYTES + 8;
    localparam int CRC_SPAN  = DATA_BYTES + 6;
    localparam int CNT_W     = $clog2(FRAME_LEN + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] pos;
    logic             in_frame;
    logic             fd_we;
    logic [FD_AW-1:0] fd_waddr;
    logic [7:0]       fd_mem [DATA_BYTES];
    logic [7:0]       fd_rdata_reg;
    frame_hdr_t       hdr_reg;

    always_comb
    begin
        pos        = frame_start ? '0 : count_reg;
        in_frame   = byte_en && (pos < CNT_W'(FRAME_LEN));
        count_next = count_reg;
        if (in_frame)
        begin
            count_next = pos + 1'b1;
        end
        fd_we     = in_frame && (pos >= CNT_W'(HDR_LEN)) && (pos < CNT_W'(CRC_SPAN));
        fd_waddr  = FD_AW'(pos - CNT_W'(HDR_LEN));
        last_byte = in_frame && (pos == CNT_W'(FRAME_LEN - 1));
        crc_ctrl.init   = byte_en && frame_start;
        crc_ctrl.update = in_frame && (pos < CNT_W'(CRC_SPAN));
        crc_ctrl.data   = byte_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_frame)
        begin
            unique case (pos)
                CNT_W'(0):             hdr_reg.addr    <= byte_value;
                CNT_W'(1):             hdr_reg.group   <= byte_value;
                CNT_W'(2):             hdr_reg.start   <= byte_value;
                CNT_W'(3):             hdr_reg.count   <= byte_value;
                CNT_W'(4):             hdr_reg.request <= byte_value;
                CNT_W'(FRAME_LEN - 2): hdr_reg.crc_hi  <= byte_value;
                CNT_W'(FRAME_LEN - 1): hdr_reg.crc_lo  <= byte_value;
                default:               ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (fd_we)
        begin
            fd_mem[fd_waddr] <= byte_value;
        end
        fd_rdata_reg <= fd_mem[fd_raddr];
    end

    assign hdr      = hdr_reg;
    assign fd_rdata = fd_rdata_reg;

endmodule

`default_nettype wire

// ----- sv/rfs_regfile.sv -----
`default_nettype none

module rfs_regfile
#(
    parameter int DEPTH = 128,
    parameter int AW    = 7
)
(
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [7:0]    wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire
